[rtl/core/bfm_pkg.sv]
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the 3x3 box mean filter
// Pixel and row widths, register codes, reset dimensions and the
// reciprocal constants for the divide by nine.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

    // pixel and window widths
    localparam int PIX_W      = 8;
    localparam int COL_SUM_W  = 10;
    localparam int SUM_W      = 12;
    localparam int MEAN_W     = 12;
    localparam int ROW_W      = 12;

    // configuration port
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int IMG_W_REG_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // frame geometry
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int IMG_WIDTH_RESET  = 512;
    localparam int IMG_HEIGHT_RESET = 512;
    localparam int MIN_DIM          = 3;

    // mean = round(sum * 16 / 9) = ((sum * 16 + 4) * RECIP_MUL) >> RECIP_SHIFT
    localparam int ROUND_BIAS  = 4;
    localparam int SCALED_W    = 16;
    localparam int RECIP_W     = 17;
    localparam int RECIP_MUL   = 58255;
    localparam int RECIP_SHIFT = 19;
    localparam int MAX_SUM     = 9 * 255;

    // one column of the window, top to bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } win_col_t;

endpackage

`default_nettype wire

[rtl/core/bfm_cell.sv]
// ----------------------------------------------------------------------------
// bfm_cell: one column of the 3x3 window
// Holds three pixels, takes the column of its left neighbour on a shift
// and presents the sum of its own column.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_cell
    import bfm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift_en,
    input  wire win_col_t             col_in,
    output win_col_t                  col_out,
    output logic [COL_SUM_W-1:0]      col_sum
);

    win_col_t col_reg;
    win_col_t col_next;

    // take the neighbour's column on every shift
    always_comb
    begin
        col_next = col_reg;
        if (shift_en)
        begin
            col_next = col_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    // column sum for the window adder
    assign col_out = col_reg;
    assign col_sum = COL_SUM_W'(col_reg.top) + COL_SUM_W'(col_reg.mid)
                   + COL_SUM_W'(col_reg.bot);

endmodule

`default_nettype wire

[rtl/core/bfm_line_store.sv]
// ----------------------------------------------------------------------------
// bfm_line_store: one image row of pixels
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_line_store
    import bfm_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(MAX_WIDTH_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]       rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [PIX_W-1:0]  wr_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/box_filter_3x3_mean.sv]
// ----------------------------------------------------------------------------
// box_filter_3x3_mean: streaming 3x3 mean filter for 8-bit grayscale frames
// Pixels enter in raster order on in_valid/in_stall, one transaction per
// pixel. Each interior pixel yields one transaction on out_valid/out_stall
// carrying round(sum * 16 / 9) in Q4, the centre column and row, and
// last_of_frame on the final interior result. Border pixels yield nothing.
// Throughput is one pixel per clock while out_stall is low; the result for
// the pixel below-right of the centre passes the input stage, the window
// adder and the divide-by-nine multiplier, then leaves the output register.
// Frame geometry comes from cfg_wr_en/cfg_index/cfg_wdata; any write to a
// register restarts the frame at column 0, row 0. Write only while idle.
// While out_stall holds, the stages behind the output register keep
// filling; in_stall rises once the input stage cannot move on.
// After reset the width is 512 (limited to MAX_WIDTH) and the height 512.
// The line stores have no reset: every entry read for an interior result
// was written earlier in the same frame, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3_mean
    import bfm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W    = $clog2(MAX_WIDTH)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      pixel,
    // result output
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [MEAN_W-1:0]          mean_q4,
    output logic [COL_W-1:0]           center_col,
    output logic [ROW_W-1:0]           center_row,
    output logic                       last_of_frame
);

    localparam int DIM_W        = 13;
    localparam int W_RESET      = (IMG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : IMG_WIDTH_RESET;
    localparam logic [COL_W-1:0] W_LAST_RESET = COL_W'(W_RESET - 1);
    localparam logic [ROW_W-1:0] H_LAST_RESET = ROW_W'(IMG_HEIGHT_RESET - 1);
    localparam int PROD_W       = SCALED_W + RECIP_W;

    // geometry and position registers
    logic [COL_W-1:0] w_last_reg, w_last_next;
    logic [ROW_W-1:0] h_last_reg, h_last_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    // input stage
    logic             a_valid_reg, a_valid_next;
    logic [PIX_W-1:0] a_pix_reg, a_pix_next;
    logic [COL_W-1:0] a_col_reg, a_col_next;
    logic [COL_W-1:0] a_ccol_reg, a_ccol_next;
    logic [ROW_W-1:0] a_crow_reg, a_crow_next;
    logic             a_interior_reg, a_interior_next;
    logic             a_last_reg, a_last_next;

    // sum stage
    logic             b_valid_reg, b_valid_next;
    logic [SUM_W-1:0] b_sum_reg, b_sum_next;
    logic [COL_W-1:0] b_ccol_reg, b_ccol_next;
    logic [ROW_W-1:0] b_crow_reg, b_crow_next;
    logic             b_last_reg, b_last_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0] out_mean_reg, out_mean_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic              out_last_reg, out_last_next;

    // handshake
    logic out_ready, b_ready, a_ready;
    logic in_fire, a_fire, b_fire;

    // configuration clamps
    logic [DIM_W-1:0] w_raw, w_clamp;
    logic [ROW_W-1:0] h_clamp;

    // window datapath
    logic [PIX_W-1:0]     top_rd, mid_rd;
    win_col_t             cur_col, cell0_col, cell1_col;
    logic [COL_SUM_W-1:0] cell0_sum, cell1_sum;
    logic [SUM_W-1:0]     window_sum;

    // divide by nine
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   product;

    // stage readiness, output register first
    assign out_ready = !out_valid_reg || !out_stall;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_fire   = in_valid && a_ready;
    assign a_fire    = a_valid_reg && b_ready;
    assign b_fire    = b_valid_reg && out_ready;
    assign in_stall  = !a_ready;

    // width limited to 3..MAX_WIDTH, height raised to at least 3
    assign w_raw   = DIM_W'(cfg_wdata[IMG_W_REG_W-1:0]);
    assign w_clamp = (w_raw < DIM_W'(MIN_DIM))   ? DIM_W'(MIN_DIM)
                   : (w_raw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_raw;
    assign h_clamp = (cfg_wdata < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg_wdata;

    // register writes and raster position
    always_comb
    begin
        w_last_next    = w_last_reg;
        h_last_next    = h_last_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  w_last_next = COL_W'(w_clamp - DIM_W'(1));
                REG_IMAGE_HEIGHT: h_last_next = h_clamp - ROW_W'(1);
                default:          w_last_next = w_last_reg;
            endcase
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (in_fire)
        begin
            if (col_count_reg == w_last_reg)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg == h_last_reg) ? '0
                               : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    // input stage: position flags worked out on the way in
    always_comb
    begin
        a_valid_next    = a_valid_reg;
        a_pix_next      = a_pix_reg;
        a_col_next      = a_col_reg;
        a_ccol_next     = a_ccol_reg;
        a_crow_next     = a_crow_reg;
        a_interior_next = a_interior_reg;
        a_last_next     = a_last_reg;
        if (a_ready)
        begin
            a_valid_next = in_valid;
        end
        if (in_fire)
        begin
            a_pix_next      = pixel;
            a_col_next      = col_count_reg;
            a_ccol_next     = col_count_reg - COL_W'(1);
            a_crow_next     = row_count_reg - ROW_W'(1);
            a_interior_next = (col_count_reg >= COL_W'(2))
                           && (row_count_reg >= ROW_W'(2));
            a_last_next     = (col_count_reg == w_last_reg)
                           && (row_count_reg == h_last_reg);
        end
    end

    // line stores, read on accept, written as the pixel enters the window
    bfm_line_store #(
        .DEPTH   (MAX_WIDTH),
        .ADDR_W  (COL_W)
    ) u_store_upper (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_count_reg),
        .rd_data (top_rd),
        .wr_en   (a_fire),
        .wr_addr (a_col_reg),
        .wr_data (mid_rd)
    );

    bfm_line_store #(
        .DEPTH   (MAX_WIDTH),
        .ADDR_W  (COL_W)
    ) u_store_middle (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_count_reg),
        .rd_data (mid_rd),
        .wr_en   (a_fire),
        .wr_addr (a_col_reg),
        .wr_data (a_pix_reg)
    );

    // window: current column feeds a chain of two column cells
    assign cur_col.top = top_rd;
    assign cur_col.mid = mid_rd;
    assign cur_col.bot = a_pix_reg;

    bfm_cell u_cell0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (a_fire),
        .col_in   (cur_col),
        .col_out  (cell0_col),
        .col_sum  (cell0_sum)
    );

    bfm_cell u_cell1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (a_fire),
        .col_in   (cell0_col),
        .col_out  (cell1_col),
        .col_sum  (cell1_sum)
    );

    assign window_sum = SUM_W'(cell0_sum) + SUM_W'(cell1_sum)
                      + SUM_W'(cur_col.top) + SUM_W'(cur_col.mid)
                      + SUM_W'(cur_col.bot);

    // sum stage, interior pixels only
    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_sum_next   = b_sum_reg;
        b_ccol_next  = b_ccol_reg;
        b_crow_next  = b_crow_reg;
        b_last_next  = b_last_reg;
        if (b_ready)
        begin
            b_valid_next = a_valid_reg && a_interior_reg;
        end
        if (a_fire)
        begin
            b_sum_next  = window_sum;
            b_ccol_next = a_ccol_reg;
            b_crow_next = a_crow_reg;
            b_last_next = a_last_reg;
        end
    end

    // divide by nine through the reciprocal, exact for this range
    assign scaled  = {b_sum_reg, 4'b0000} + SCALED_W'(ROUND_BIAS);
    assign product = PROD_W'(scaled) * PROD_W'(RECIP_MUL);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_mean_next  = out_mean_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        if (out_ready)
        begin
            out_valid_next = b_valid_reg;
        end
        if (b_fire)
        begin
            out_mean_next = product[RECIP_SHIFT +: MEAN_W];
            out_col_next  = b_ccol_reg;
            out_row_next  = b_crow_reg;
            out_last_next = b_last_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg    <= W_LAST_RESET;
            h_last_reg    <= H_LAST_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_last_reg    <= w_last_next;
            h_last_reg    <= h_last_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_pix_reg      <= a_pix_next;
        a_col_reg      <= a_col_next;
        a_ccol_reg     <= a_ccol_next;
        a_crow_reg     <= a_crow_next;
        a_interior_reg <= a_interior_next;
        a_last_reg     <= a_last_next;
        b_sum_reg      <= b_sum_next;
        b_ccol_reg     <= b_ccol_next;
        b_crow_reg     <= b_crow_next;
        b_last_reg     <= b_last_next;
        out_mean_reg   <= out_mean_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign mean_q4       = out_mean_reg;
    assign center_col    = out_col_reg;
    assign center_row    = out_row_reg;
    assign last_of_frame = out_last_reg;

    // stall only while the input stage is occupied and blocked
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // raster position stays inside the configured frame
    a_position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (col_count_reg <= w_last_reg) && (row_count_reg <= h_last_reg))
        else $error("raster position outside frame");

    // an accepted pixel moves the column on by one within a row
    a_column_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_wr_en && (col_count_reg != w_last_reg))
        |=> (col_count_reg == $past(col_count_reg) + COL_W'(1)))
        else $error("column counter did not advance");

    // frame end mark sits on the bottom-right interior centre
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg)
        |-> ((out_col_reg == w_last_reg - COL_W'(1))
             && (out_row_reg == h_last_reg - ROW_W'(1))))
        else $error("last_of_frame on wrong centre");

    // window sum never exceeds nine full-scale pixels
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_sum_reg <= SUM_W'(MAX_SUM)))
        else $error("window sum out of range");

endmodule

`default_nettype wire

[verif/box_filter_3x3_mean_checker.sv]
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_checker: result predictor and scoreboard
// Watches the configuration port and both pixel channels, keeps its own
// line stores, window and frame counters, predicts the window mean of every
// interior pixel and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean_checker
    import bfm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W    = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [MEAN_W-1:0]     mean_q4,
    input  logic [COL_W-1:0]      center_col,
    input  logic [ROW_W-1:0]      center_row,
    input  logic                  last_of_frame,
    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } window_mean_t;

    // shadow of the block's frame state
    logic [PIX_W-1:0]       upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]       middle_row [MAX_WIDTH];
    logic [PIX_W-1:0]       window_cols [6];
    int unsigned            next_col;
    int unsigned            next_row;
    logic [IMG_W_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;

    window_mean_t expected_means [$];
    int           error_count = 0;

    task automatic report_field(input string field, input int unsigned want_val,
                                input int unsigned got_val);
        error_count++;
        $display("%0t: %s mismatch: expected %0d actual %0d", $time, field,
                 want_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        window_mean_t     got;
        window_mean_t     want;
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      sum;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 6; i++)
                window_cols[i] = '0;
            next_col   = 0;
            next_row   = 0;
            width_reg  = IMG_W_REG_W'(IMG_WIDTH_RESET);
            height_reg = ROW_W'(IMG_HEIGHT_RESET);
            expected_means.delete();
            pending    <= 0;
            mismatches <= error_count;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = {mean_q4, center_col, center_row, last_of_frame};
                if (expected_means.size() == 0)
                begin
                    error_count++;
                    $display("%0t: extra result: expected none actual mean %0d col %0d row %0d",
                             $time, got.mean, got.col, got.row);
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (got.mean !== want.mean) report_field("mean_q4", want.mean, got.mean);
                    if (got.col !== want.col)   report_field("center_col", want.col, got.col);
                    if (got.row !== want.row)   report_field("center_row", want.row, got.row);
                    if (got.last !== want.last)
                        report_field("last_of_frame", want.last, got.last);
                end
            end

            // register write restarts the frame
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_wdata[IMG_W_REG_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_wdata[ROW_W-1:0];
                next_col = 0;
                next_row = 0;
            end

            // pixel transaction: slide the window and predict
            if (in_valid && !in_stall)
            begin
                w = width_reg;
                if (w < MIN_DIM) w = MIN_DIM;
                if (w > MAX_WIDTH) w = MAX_WIDTH;
                h = height_reg;
                if (h < MIN_DIM) h = MIN_DIM;
                c = (next_col >= MAX_WIDTH) ? 0 : next_col;
                r = next_row;
                top = upper_row[c];
                mid = middle_row[c];

                if (r >= 2 && c >= 2)
                begin
                    sum = top + mid + pixel;
                    for (int k = 0; k < 6; k++)
                        sum += window_cols[k];
                    want.mean = MEAN_W'((sum * 16 + ROUND_BIAS) / 9);
                    want.col  = COL_W'(c - 1);
                    want.row  = ROW_W'(r - 1);
                    want.last = (r + 1 == h) && (c + 1 == w);
                    expected_means.push_back(want);
                end

                upper_row[c]   = mid;
                middle_row[c]  = pixel;
                window_cols[0] = window_cols[3];
                window_cols[1] = window_cols[4];
                window_cols[2] = window_cols[5];
                window_cols[3] = top;
                window_cols[4] = mid;
                window_cols[5] = pixel;

                c++;
                if (c >= w)
                begin
                    c = 0;
                    r++;
                    if (r >= h) r = 0;
                end
                next_col = c;
                next_row = r;
            end

            pending    <= expected_means.size();
            mismatches <= error_count;
        end
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for the 3x3 box mean filter
// Drives frames of random pixels under changing geometry, with random gaps
// on the sender and stalls on the receiver, a long output hold-off and
// drains between frames. The checker predicts and compares; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfm_pkg::*;

    localparam int MAX_WIDTH     = MAX_WIDTH_DEF;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PIXELS = 960;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel;
    logic                  out_valid;
    logic                  out_stall;
    logic [MEAN_W-1:0]     mean_q4;
    logic [COL_W-1:0]      center_col;
    logic [ROW_W-1:0]      center_row;
    logic                  last_of_frame;

    int                     mismatches;
    int                     pending;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     pixels_sent;
    int                     hold_requests;
    logic [IMG_W_REG_W-1:0] width_shadow;
    logic [ROW_W-1:0]       height_shadow;

    box_filter_3x3_mean #(.MAX_WIDTH(MAX_WIDTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_q4       (mean_q4),
        .center_col    (center_col),
        .center_row    (center_row),
        .last_of_frame (last_of_frame)
    );

    box_filter_3x3_mean_checker #(.MAX_WIDTH(MAX_WIDTH)) mean_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_q4       (mean_q4),
        .center_col    (center_col),
        .center_row    (center_row),
        .last_of_frame (last_of_frame),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                hold_left    = HOLD_CYCLES;
                holds_served = hold_requests;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return PIX_W'($urandom_range(255));
    endfunction

    // one pixel transaction, with a random gap in front
    task automatic push_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (index == REG_IMAGE_WIDTH)
            width_shadow = data[IMG_W_REG_W-1:0];
        else
            height_shadow = data[ROW_W-1:0];
    endtask

    // stop sending and wait until every predicted result has left the block
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input logic [CFG_DATA_W-1:0] w_data,
                              input logic [CFG_DATA_W-1:0] h_data, input int count);
        write_reg(REG_IMAGE_WIDTH, w_data);
        write_reg(REG_IMAGE_HEIGHT, h_data);
        repeat (count) push_pixel(random_pixel());
        wait_idle();
    endtask

    // small frames: full, back to back, or cut short
    task automatic run_random_phase(input int quota);
        int                    first;
        int                    pick;
        int                    w;
        int                    h;
        int                    used_w;
        int                    used_h;
        int                    count;
        logic [CFG_DATA_W-1:0] w_data;
        first = pixels_sent;
        while (pixels_sent - first < quota)
        begin
            pick = $urandom_range(99);
            w = (pick < 85) ? $urandom_range(10, 3)
              : (pick < 93) ? $urandom_range(24, 11) : $urandom_range(2, 0);
            pick = $urandom_range(99);
            h = (pick < 85) ? $urandom_range(7, 3)
              : (pick < 93) ? $urandom_range(16, 8) : $urandom_range(2, 0);
            // top bit of the width word is not part of the register
            w_data = CFG_DATA_W'(w) | (CFG_DATA_W'($urandom_range(1)) << IMG_W_REG_W);

            pick = $urandom_range(99);
            if (pick < 15)
                write_reg(REG_IMAGE_WIDTH, w_data);
            else if (pick < 25)
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            else
            begin
                write_reg(REG_IMAGE_WIDTH, w_data);
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            end

            used_w = (width_shadow < MIN_DIM) ? MIN_DIM
                   : (width_shadow > MAX_WIDTH) ? MAX_WIDTH : width_shadow;
            used_h = (height_shadow < MIN_DIM) ? MIN_DIM : height_shadow;
            pick = $urandom_range(99);
            if (pick < 70)
                count = used_w * used_h;
            else if (pick < 85)
                count = 2 * used_w * used_h;
            else
                count = $urandom_range(used_w * used_h - 1, 1);

            repeat (count) push_pixel(random_pixel());
            wait_idle();
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [PIX_W-1:0] corner_pixels [12];
        corner_pixels = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA,
                          8'hFE, 8'h7F, 8'h00, 8'hFF, 8'hFF, 8'h00};
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        pixel         = '0;
        hold_requests = 0;
        pixels_sent   = 0;
        width_shadow  = IMG_W_REG_W'(IMG_WIDTH_RESET);
        height_shadow = ROW_W'(IMG_HEIGHT_RESET);
        send_idle_pct = 20;
        recv_idle_pct = 62;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: start of the first row, no interior pixel yet
        repeat (20) push_pixel(random_pixel());
        wait_idle();

        // width and height below the minimum, all-white frame
        write_reg(REG_IMAGE_WIDTH, 12'd0);
        write_reg(REG_IMAGE_HEIGHT, 12'd1);
        repeat (9) push_pixel(8'hFF);
        wait_idle();

        // frame abandoned part way, then restarted by a single write
        write_reg(REG_IMAGE_WIDTH, 12'd4);
        repeat (5) push_pixel(8'h5A);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 12'd3);
        for (int i = 0; i < 12; i++)
            push_pixel(corner_pixels[i]);
        wait_idle();

        // width above the store, clamped to full width, first pixels only
        send_frame(12'h7FF, 12'h000, 20);
        // tallest height, cut short
        send_frame(12'h803, 12'hFFF, 15);
        // small height again before the random frames
        write_reg(REG_IMAGE_HEIGHT, 12'd5);

        run_random_phase(RANDOM_PIXELS / 3);

        send_idle_pct = 62;
        recv_idle_pct = 20;
        run_random_phase(RANDOM_PIXELS / 3);

        // long output hold-off while pixels keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        send_frame(12'd10, 12'd20, 200);
        run_random_phase(RANDOM_PIXELS / 3);

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
